FILE: design/brb_pkg.sv
// shared types, constants and functions for the byte ring buffer
package brb_pkg;

    // fixed field widths
    localparam int PTR_W  = 11;
    localparam int BYTE_W = 8;
    localparam int OFS_W  = 10;
    localparam int KIND_W = 2;

    // requested capacity after reset
    localparam logic [PTR_W-1:0] CAP_RESET = 11'd1024;

    // item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH = 2'd0,
        KIND_POP  = 2'd1,
        KIND_PEEK = 2'd2,
        KIND_DROP = 2'd3
    } kind_t;

    // memory access issued for one transfer
    typedef struct packed {
        logic              wr;
        logic              rd;
        logic [PTR_W-1:0]  addr;
        logic [BYTE_W-1:0] wdata;
    } mem_req_t;

    // result fields known before the memory read returns
    typedef struct packed {
        logic             accepted;
        logic             is_read;
        logic [PTR_W-1:0] used;
        logic [PTR_W-1:0] free;
        logic             empty;
        logic             full;
    } result_t;

    // limit the request to the storage depth and round down to a power of two
    function automatic logic [PTR_W-1:0] eff_cap(input logic [PTR_W-1:0] req,
                                                 input int unsigned depth);
        logic [PTR_W-1:0] lim;
        logic [PTR_W-1:0] res;
        lim = req;
        res = '0;
        if (32'(req) > depth)
        begin
            lim = depth[PTR_W-1:0];
        end
        for (int i = 0; i < PTR_W; i++)
        begin
            if (lim[i])
            begin
                res = PTR_W'(1) << i;
            end
        end
        return res;
    endfunction

endpackage

FILE: design/brb_mem.sv
// byte storage: one write port, one registered read port
module brb_mem #(
    parameter int MEM_DEPTH = 1024,
    parameter int AW        = 10
) (
    input  logic                      clk,
    input  logic                      wr,
    input  logic                      rd,
    input  logic [AW-1:0]             addr,
    input  logic [brb_pkg::BYTE_W-1:0] wdata,
    output logic [brb_pkg::BYTE_W-1:0] rdata
);

    logic [brb_pkg::BYTE_W-1:0] mem [MEM_DEPTH];
    logic [brb_pkg::BYTE_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[addr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/brb_ctrl.sv
// pointer, capacity and count logic of the byte ring buffer
module brb_ctrl #(
    parameter int DEPTH = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [brb_pkg::PTR_W-1:0]   cfg_wr_data,
    input  logic                        advance,
    input  logic [brb_pkg::KIND_W-1:0]  kind,
    input  logic [brb_pkg::BYTE_W-1:0]  data_byte,
    input  logic [brb_pkg::OFS_W-1:0]   peek_offset,
    input  logic [brb_pkg::PTR_W-1:0]   drop_count,
    output brb_pkg::mem_req_t           mem_req,
    output brb_pkg::result_t            result
);

    localparam logic [brb_pkg::PTR_W-1:0] CAP_RST =
        brb_pkg::eff_cap(brb_pkg::CAP_RESET, DEPTH);

    logic [brb_pkg::PTR_W-1:0] wp_reg, wp_next;
    logic [brb_pkg::PTR_W-1:0] rp_reg, rp_next;
    logic [brb_pkg::PTR_W-1:0] cap_reg;

    logic                      cap_on;
    logic [brb_pkg::PTR_W-1:0] mask;
    logic [brb_pkg::PTR_W-1:0] used;
    logic [brb_pkg::PTR_W-1:0] used_after;
    logic [brb_pkg::PTR_W-1:0] drop_amt;
    logic [brb_pkg::PTR_W-1:0] peek_ptr;
    logic                      push_ok, pop_ok, peek_ok;
    brb_pkg::kind_t            kind_dec;

    assign cap_on   = (cap_reg != '0);
    assign mask     = cap_on ? (cap_reg - 1'b1) : '0;
    assign used     = wp_reg - rp_reg;
    assign kind_dec = brb_pkg::kind_t'(kind);
    assign peek_ptr = rp_reg + {1'b0, peek_offset};
    assign drop_amt = (drop_count > used) ? used : drop_count;
    assign push_ok  = cap_on && (used < cap_reg);
    assign pop_ok   = cap_on && (used != '0);
    assign peek_ok  = cap_on && ({1'b0, peek_offset} < used);

    // decode the item into pointer moves and a memory access
    always_comb
    begin
        wp_next          = wp_reg;
        rp_next          = rp_reg;
        mem_req.wr       = 1'b0;
        mem_req.rd       = 1'b0;
        mem_req.addr     = rp_reg & mask;
        mem_req.wdata    = data_byte;
        result.accepted  = 1'b0;
        result.is_read   = 1'b0;
        unique case (kind_dec)
            brb_pkg::KIND_PUSH:
            begin
                mem_req.addr    = wp_reg & mask;
                mem_req.wr      = push_ok && advance;
                result.accepted = push_ok;
                if (push_ok)
                begin
                    wp_next = wp_reg + 1'b1;
                end
            end
            brb_pkg::KIND_POP:
            begin
                mem_req.rd      = pop_ok && advance;
                result.accepted = pop_ok;
                result.is_read  = pop_ok;
                if (pop_ok)
                begin
                    rp_next = rp_reg + 1'b1;
                end
            end
            brb_pkg::KIND_PEEK:
            begin
                mem_req.addr    = peek_ptr & mask;
                mem_req.rd      = peek_ok && advance;
                result.accepted = peek_ok;
                result.is_read  = peek_ok;
            end
            brb_pkg::KIND_DROP:
            begin
                result.accepted = cap_on;
                if (cap_on)
                begin
                    rp_next = rp_reg + drop_amt;
                end
            end
            default:
            begin
                result.accepted = 1'b0;
            end
        endcase

        // counts and flags after the item
        used_after   = wp_next - rp_next;
        result.used  = used_after;
        result.free  = cap_on ? (cap_reg - used_after) : '0;
        result.empty = cap_on && (used_after == '0);
        result.full  = !cap_on || (used_after == cap_reg);
    end

    // pointers and capacity; a capacity write empties the ring
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cap_reg <= CAP_RST;
        end
        else if (cfg_wr_en)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cap_reg <= brb_pkg::eff_cap(cfg_wr_data, DEPTH);
        end
        else if (advance)
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
        end
    end

endmodule

FILE: design/byte_ring_buffer_with_peek_drop_unit.sv
// Byte ring buffer with push, pop, peek at an offset and drop of several bytes.
// The capacity register is limited to DEPTH and rounded down to a power of two;
// zero disables the ring, and any write to it empties the ring. Each transfer
// in gives one transfer out with the accept flag, the byte read, and the used
// count, free count, empty and full after the item. One item is taken per
// clock while the input is not stalled; its result passes through stage one
// and the output register: the storage read is issued at the accepting edge,
// and the output register captures the read data when stage one moves on.
// The input stalls only while the output side holds back a finished result.
module byte_ring_buffer_with_peek_drop_unit #(
    parameter int DEPTH = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [brb_pkg::PTR_W-1:0]   cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [brb_pkg::KIND_W-1:0]  kind,
    input  logic [brb_pkg::BYTE_W-1:0]  data_byte,
    input  logic [brb_pkg::OFS_W-1:0]   peek_offset,
    input  logic [brb_pkg::PTR_W-1:0]   drop_count,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        accepted,
    output logic [brb_pkg::BYTE_W-1:0]  read_byte,
    output logic [brb_pkg::PTR_W-1:0]   used_count,
    output logic [brb_pkg::PTR_W-1:0]   free_count,
    output logic                        is_empty,
    output logic                        is_full
);

    localparam int MEM_DEPTH = (DEPTH < 1024) ? DEPTH : 1024;
    localparam int AW        = $clog2(MEM_DEPTH);

    brb_pkg::mem_req_t          mem_req;
    brb_pkg::result_t           result;
    logic [brb_pkg::BYTE_W-1:0] rdata;

    logic             in_accept;
    logic             s1_move;
    logic             s1_valid_reg, s1_valid_next;
    brb_pkg::result_t s1_info_reg;
    logic             out_valid_reg, out_valid_next;

    logic                      acc_reg;
    logic [brb_pkg::BYTE_W-1:0] byte_reg;
    logic [brb_pkg::PTR_W-1:0]  used_reg;
    logic [brb_pkg::PTR_W-1:0]  free_reg;
    logic                      empty_reg;
    logic                      full_reg;

    // pointer and count logic
    brb_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .advance     (in_accept),
        .kind        (kind),
        .data_byte   (data_byte),
        .peek_offset (peek_offset),
        .drop_count  (drop_count),
        .mem_req     (mem_req),
        .result      (result)
    );

    // byte storage
    brb_mem #(
        .MEM_DEPTH (MEM_DEPTH),
        .AW        (AW)
    ) u_mem (
        .clk   (clk),
        .wr    (mem_req.wr),
        .rd    (mem_req.rd),
        .addr  (mem_req.addr[AW-1:0]),
        .wdata (mem_req.wdata),
        .rdata (rdata)
    );

    // handshake: stage one waits on the read, then moves to the output register
    assign s1_move   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_move;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg && out_stall;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // stage one payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_info_reg <= result;
        end
    end

    // output payload, read data joins here
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            acc_reg   <= s1_info_reg.accepted;
            byte_reg  <= s1_info_reg.is_read ? rdata : '0;
            used_reg  <= s1_info_reg.used;
            free_reg  <= s1_info_reg.free;
            empty_reg <= s1_info_reg.empty;
            full_reg  <= s1_info_reg.full;
        end
    end

    assign out_valid  = out_valid_reg;
    assign accepted   = acc_reg;
    assign read_byte  = byte_reg;
    assign used_count = used_reg;
    assign free_count = free_reg;
    assign is_empty   = empty_reg;
    assign is_full    = full_reg;

endmodule

FILE: tb/sv/byte_ring_buffer_with_peek_drop_unit_tb.sv
// testbench for the byte ring buffer: directed table, random phases, ring predictor
`timescale 1ns / 100ps

module byte_ring_buffer_with_peek_drop_unit_tb;

    // one result transfer as the ring should report it
    typedef struct packed {
        logic                       acc;
        logic [brb_pkg::BYTE_W-1:0] rbyte;
        logic [brb_pkg::PTR_W-1:0]  used;
        logic [brb_pkg::PTR_W-1:0]  free;
        logic                       empty;
        logic                       full;
    } ring_result_t;

    // one line of the directed table: a capacity write or an item
    typedef struct packed {
        logic                       is_cfg;
        logic [brb_pkg::PTR_W-1:0]  cfg_val;
        brb_pkg::kind_t             k;
        logic [brb_pkg::BYTE_W-1:0] d;
        logic [brb_pkg::OFS_W-1:0]  o;
        logic [brb_pkg::PTR_W-1:0]  n;
        logic                       fixed;
        ring_result_t               res;
    } stim_row_t;

    localparam int RING_DEPTH = 1024;
    localparam int MAX_WAIT   = 13;
    localparam int HOLD_LEN   = 300;
    localparam int N_ROWS     = 29;
    localparam int N_PHASES   = 12;

    logic                       clk;
    logic                       rst_n       = 1'b0;
    logic                       cfg_wr_en   = 1'b0;
    logic [brb_pkg::PTR_W-1:0]  cfg_wr_data = '0;
    logic                       in_valid    = 1'b0;
    logic                       in_stall;
    brb_pkg::kind_t             kind        = brb_pkg::KIND_PUSH;
    logic [brb_pkg::BYTE_W-1:0] data_byte   = '0;
    logic [brb_pkg::OFS_W-1:0]  peek_offset = '0;
    logic [brb_pkg::PTR_W-1:0]  drop_count  = '0;
    logic                       out_valid;
    logic                       out_stall   = 1'b0;
    logic                       accepted;
    logic [brb_pkg::BYTE_W-1:0] read_byte;
    logic [brb_pkg::PTR_W-1:0]  used_count;
    logic [brb_pkg::PTR_W-1:0]  free_count;
    logic                       is_empty;
    logic                       is_full;

    // predictor state
    logic [brb_pkg::BYTE_W-1:0] ring_mem [0:RING_DEPTH-1];
    logic [brb_pkg::PTR_W-1:0]  wr_ptr  = '0;
    logic [brb_pkg::PTR_W-1:0]  rd_ptr  = '0;
    logic [brb_pkg::PTR_W-1:0]  cap_req = brb_pkg::CAP_RESET;

    ring_result_t        expected_results [$];
    int                  mismatches = 0;
    bit                  send_idle  = 1'b1;
    int                  hold_seq   = 0;

    byte_ring_buffer_with_peek_drop_unit #(
        .DEPTH(RING_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .data_byte(data_byte),
        .peek_offset(peek_offset),
        .drop_count(drop_count),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .accepted(accepted),
        .read_byte(read_byte),
        .used_count(used_count),
        .free_count(free_count),
        .is_empty(is_empty),
        .is_full(is_full)
    );

    // usable ring size: saturate to the depth, then largest power of two not above
    function automatic logic [brb_pkg::PTR_W-1:0] ring_size(
        input logic [brb_pkg::PTR_W-1:0] req);
        logic [brb_pkg::PTR_W-1:0] size;
        size = '0;
        for (int p = RING_DEPTH; p >= 1; p = p / 2)
        begin
            if (size == 0 && int'(req) >= p)
            begin
                size = brb_pkg::PTR_W'(p);
            end
        end
        return size;
    endfunction

    // apply one item to the predictor state and return the status it reports
    function automatic ring_result_t predict_item(input brb_pkg::kind_t k,
                                                  input logic [brb_pkg::BYTE_W-1:0] d,
                                                  input logic [brb_pkg::OFS_W-1:0] o,
                                                  input logic [brb_pkg::PTR_W-1:0] n);
        ring_result_t res;
        logic [brb_pkg::PTR_W-1:0] size;
        logic [brb_pkg::PTR_W-1:0] mask;
        logic [brb_pkg::PTR_W-1:0] used;
        size = ring_size(cap_req);
        mask = size - 1'b1;
        used = wr_ptr - rd_ptr;
        res  = '0;
        case (k)
            brb_pkg::KIND_PUSH:
            begin
                if (size != 0 && used < size)
                begin
                    ring_mem[wr_ptr & mask] = d;
                    wr_ptr = wr_ptr + 1'b1;
                    res.acc = 1'b1;
                end
            end
            brb_pkg::KIND_POP:
            begin
                if (size != 0 && used != 0)
                begin
                    res.rbyte = ring_mem[rd_ptr & mask];
                    rd_ptr = rd_ptr + 1'b1;
                    res.acc = 1'b1;
                end
            end
            brb_pkg::KIND_PEEK:
            begin
                if (size != 0 && brb_pkg::PTR_W'(o) < used)
                begin
                    res.rbyte = ring_mem[brb_pkg::PTR_W'(rd_ptr + brb_pkg::PTR_W'(o)) & mask];
                    res.acc = 1'b1;
                end
            end
            default:
            begin
                // drop never moves the read side past the write side
                if (size != 0)
                begin
                    rd_ptr = rd_ptr + ((n > used) ? used : n);
                    res.acc = 1'b1;
                end
            end
        endcase
        used       = wr_ptr - rd_ptr;
        res.used   = used;
        res.free   = (size != 0) ? size - used : '0;
        res.empty  = (size != 0 && used == 0);
        res.full   = (size == 0 || used == size);
        return res;
    endfunction

    // table rows
    function automatic stim_row_t cap_row(input int v);
        stim_row_t r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.cfg_val = brb_pkg::PTR_W'(v);
        return r;
    endfunction

    function automatic stim_row_t pred_row(input brb_pkg::kind_t k, input int d, input int o,
                                           input int n);
        stim_row_t r;
        r = '0;
        r.k = k;
        r.d = brb_pkg::BYTE_W'(d);
        r.o = brb_pkg::OFS_W'(o);
        r.n = brb_pkg::PTR_W'(n);
        return r;
    endfunction

    function automatic stim_row_t exp_row(input brb_pkg::kind_t k, input int d, input int o,
                                          input int n, input int acc, input int rb,
                                          input int u, input int f, input int e,
                                          input int fu);
        stim_row_t r;
        r = pred_row(k, d, o, n);
        r.fixed     = 1'b1;
        r.res.acc   = acc[0];
        r.res.rbyte = brb_pkg::BYTE_W'(rb);
        r.res.used  = brb_pkg::PTR_W'(u);
        r.res.free  = brb_pkg::PTR_W'(f);
        r.res.empty = e[0];
        r.res.full  = fu[0];
        return r;
    endfunction

    // directed table: empty ring, extremes, a one-byte ring, disabled, saturation, wrap
    stim_row_t script [0:N_ROWS-1] = '{
        exp_row(brb_pkg::KIND_POP,  0,    0,    0,    0, 0,    0, 1024, 1, 0),
        exp_row(brb_pkg::KIND_PEEK, 0,    0,    0,    0, 0,    0, 1024, 1, 0),
        exp_row(brb_pkg::KIND_DROP, 0,    0,    1024, 1, 0,    0, 1024, 1, 0),
        exp_row(brb_pkg::KIND_PUSH, 0,    0,    0,    1, 0,    1, 1023, 0, 0),
        exp_row(brb_pkg::KIND_PUSH, 255,  0,    0,    1, 0,    2, 1022, 0, 0),
        exp_row(brb_pkg::KIND_PEEK, 0,    1,    0,    1, 255,  2, 1022, 0, 0),
        exp_row(brb_pkg::KIND_PEEK, 0,    1023, 0,    0, 0,    2, 1022, 0, 0),
        exp_row(brb_pkg::KIND_POP,  0,    0,    0,    1, 0,    1, 1023, 0, 0),
        exp_row(brb_pkg::KIND_DROP, 0,    0,    2047, 1, 0,    0, 1024, 1, 0),
        cap_row(1),
        exp_row(brb_pkg::KIND_PUSH, 165,  0,    0,    1, 0,    1, 0,    0, 1),
        exp_row(brb_pkg::KIND_PUSH, 90,   0,    0,    0, 0,    1, 0,    0, 1),
        exp_row(brb_pkg::KIND_PEEK, 0,    0,    0,    1, 165,  1, 0,    0, 1),
        exp_row(brb_pkg::KIND_POP,  0,    0,    0,    1, 165,  0, 1,    1, 0),
        cap_row(0),
        exp_row(brb_pkg::KIND_PUSH, 17,   0,    0,    0, 0,    0, 0,    0, 1),
        exp_row(brb_pkg::KIND_POP,  0,    0,    0,    0, 0,    0, 0,    0, 1),
        exp_row(brb_pkg::KIND_PEEK, 0,    0,    0,    0, 0,    0, 0,    0, 1),
        exp_row(brb_pkg::KIND_DROP, 0,    0,    5,    0, 0,    0, 0,    0, 1),
        cap_row(2047),
        exp_row(brb_pkg::KIND_PUSH, 60,   0,    0,    1, 0,    1, 1023, 0, 0),
        cap_row(3),
        exp_row(brb_pkg::KIND_PUSH, 1,    0,    0,    1, 0,    1, 1,    0, 0),
        exp_row(brb_pkg::KIND_PUSH, 2,    0,    0,    1, 0,    2, 0,    0, 1),
        pred_row(brb_pkg::KIND_POP,  0,   0,    0),
        pred_row(brb_pkg::KIND_PUSH, 3,   0,    0),
        pred_row(brb_pkg::KIND_PEEK, 0,   1,    0),
        pred_row(brb_pkg::KIND_DROP, 0,   0,    1),
        pred_row(brb_pkg::KIND_POP,  0,   0,    0)
    };

    // count and print one mismatch
    task automatic report_mismatch(input string what, input int want, input int got);
        $display("mismatch: %s expected %0d got %0d at %0t", what, want, got, $time);
        mismatches++;
    endtask

    // offer one item after a random gap and record its expected result on transfer
    task automatic send_item(input brb_pkg::kind_t k, input logic [brb_pkg::BYTE_W-1:0] d,
                             input logic [brb_pkg::OFS_W-1:0] o,
                             input logic [brb_pkg::PTR_W-1:0] n,
                             input logic fixed, input ring_result_t want);
        int gap;
        ring_result_t res;
        gap = send_idle ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        data_byte   <= d;
        peek_offset <= o;
        drop_count  <= n;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        res = predict_item(k, d, o, n);
        expected_results.push_back(fixed ? want : res);
    endtask

    // capacity write once every result is out; it also empties the ring
    task automatic write_capacity(input logic [brb_pkg::PTR_W-1:0] v);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cap_req = v;
        wr_ptr  = '0;
        rd_ptr  = '0;
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // result side: check each transfer, random stalls, one long hold on request
    initial
    begin
        int wait_left;
        int results_done;
        int hold_seen;
        bit recv_idle;
        ring_result_t want;
        wait_left    = 0;
        results_done = 0;
        hold_seen    = 0;
        recv_idle    = 1'b1;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result with nothing pending", 0, 1);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (accepted !== want.acc)
                    begin
                        report_mismatch("accepted", want.acc, accepted);
                    end
                    if (read_byte !== want.rbyte)
                    begin
                        report_mismatch("read_byte", want.rbyte, read_byte);
                    end
                    if (used_count !== want.used)
                    begin
                        report_mismatch("used_count", want.used, used_count);
                    end
                    if (free_count !== want.free)
                    begin
                        report_mismatch("free_count", want.free, free_count);
                    end
                    if (is_empty !== want.empty)
                    begin
                        report_mismatch("is_empty", want.empty, is_empty);
                    end
                    if (is_full !== want.full)
                    begin
                        report_mismatch("is_full", want.full, is_full);
                    end
                end
                wait_left = recv_idle ? $urandom_range(0, MAX_WAIT) : 0;
                results_done++;
                if (results_done % 64 == 0)
                begin
                    recv_idle = $urandom_range(0, 1);
                end
            end
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                wait_left = HOLD_LEN;
            end
            if (wait_left > 0)
            begin
                out_stall <= 1'b1;
                wait_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // item side: reset, directed table, then random phases over several capacities
    initial
    begin
        logic [brb_pkg::PTR_W-1:0] phase_caps [0:N_PHASES-1];
        logic [brb_pkg::BYTE_W-1:0] d;
        logic [brb_pkg::OFS_W-1:0] o;
        logic [brb_pkg::PTR_W-1:0] n;
        brb_pkg::kind_t k;
        int n_items;
        int fill;
        int push_pct;
        int choice;
        int sel;
        phase_caps = '{11'd1024, 11'd16, 11'd1, 11'd0, 11'd2, 11'd2047, 11'd100, 11'd8,
                       11'd5, 11'd1023, 11'd64, 11'd0};
        phase_caps[N_PHASES-1] = brb_pkg::PTR_W'($urandom_range(0, 2047));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < N_ROWS; i++)
        begin
            if (script[i].is_cfg)
            begin
                write_capacity(script[i].cfg_val);
            end
            else
            begin
                send_item(script[i].k, script[i].d, script[i].o, script[i].n,
                          script[i].fixed, script[i].res);
            end
        end

        // random phases; fill and drain bursts so small rings hit full and empty often
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            write_capacity(phase_caps[ph]);
            send_idle = ($urandom_range(0, 3) != 0);
            if (ph == 1)
            begin
                // long output hold while items keep coming, so the input backs up
                hold_seq++;
            end
            n_items = (ring_size(phase_caps[ph]) == 0) ? 20 : 170;
            for (int i = 0; i < n_items; i++)
            begin
                fill     = int'(brb_pkg::PTR_W'(wr_ptr - rd_ptr));
                push_pct = ((i / 40) % 2 == 0) ? 65 : 30;
                choice   = $urandom_range(0, 99);
                if (choice < push_pct)
                begin
                    k = brb_pkg::KIND_PUSH;
                end
                else if (choice < push_pct + 25)
                begin
                    k = brb_pkg::KIND_POP;
                end
                else if (choice < push_pct + 37)
                begin
                    k = brb_pkg::KIND_PEEK;
                end
                else
                begin
                    k = brb_pkg::KIND_DROP;
                end
                d = brb_pkg::BYTE_W'($urandom);
                if ($urandom_range(0, 7) == 0)
                begin
                    o = brb_pkg::OFS_W'($urandom);
                end
                else
                begin
                    o = brb_pkg::OFS_W'($urandom_range(0, fill + 1));
                end
                sel = $urandom_range(0, 15);
                if (sel == 0)
                begin
                    n = brb_pkg::PTR_W'($urandom);
                end
                else if (sel < 4)
                begin
                    n = brb_pkg::PTR_W'($urandom_range(0, fill + 2));
                end
                else
                begin
                    n = brb_pkg::PTR_W'($urandom_range(0, 3));
                end
                send_item(k, d, o, n, 1'b0, '0);
            end
        end

        // drain and let the pipeline settle
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            report_mismatch("results never delivered", 0, expected_results.size());
        end
        if (mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: byte_ring_buffer_with_peek_drop_unit.f
design/brb_pkg.sv
design/brb_mem.sv
design/brb_ctrl.sv
design/byte_ring_buffer_with_peek_drop_unit.sv
tb/sv/byte_ring_buffer_with_peek_drop_unit_tb.sv
